// File: design/gib_pkg.sv
// Package: shared constants and types for the grid index boundary bits block.
`default_nettype none
package gib_pkg;
  localparam int AXIS_MAX_DEF   = 1024;
  localparam int INDEX_BITS_DEF = 30;
  localparam int NUM_AXES       = 3;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 11;
  localparam int COORD_W        = 10;
  localparam int BND_W          = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AXIS_X = 2'd0,
    REG_AXIS_Y = 2'd1,
    REG_AXIS_Z = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_VERTEX = 1'b0,
    OP_CUBE   = 1'b1
  } op_t;
endpackage
`default_nettype wire

// File: design/gib_if.sv
// Interfaces: valid/ready channels for index words and result words.
`default_nettype none
interface gib_in_if #(parameter int INDEX_BITS = 30);
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [INDEX_BITS-1:0] grid_index;
  modport source (output valid, output opcode, output grid_index, input ready);
  modport sink   (input valid, input opcode, input grid_index, output ready);
endinterface

interface gib_out_if #(parameter int COORD_W = 10);
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;
  logic [COORD_W-1:0] coord_z;
  logic [2:0]         lower_bounds;
  logic [2:0]         upper_bounds;
  modport source (output valid, output coord_x, output coord_y, output coord_z,
                  output lower_bounds, output upper_bounds, input ready);
  modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                  input lower_bounds, input upper_bounds, output ready);
endinterface
`default_nettype wire

// File: design/gib_cell.sv
// Cell: one restoring-division step of the quotient against one axis size.
`default_nettype none
module gib_cell #(
  parameter int QW = 30,
  parameter int SW = 11,
  parameter int BIT = 0
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [QW-1:0] num_i,
  input  wire logic [SW:0]   rem_i,
  input  wire logic [SW-1:0] size_i,
  output logic      [QW-1:0] num_o,
  output logic      [SW:0]   rem_o
);
  logic [SW:0]   trial;
  logic [SW:0]   diff;
  logic [QW-1:0] num_nxt;
  logic [SW:0]   rem_nxt;
  logic [QW-1:0] num_r;
  logic [SW:0]   rem_r;

  always_comb begin
    // shift in the next numerator bit, subtract when it fits
    trial   = {rem_i[SW-1:0], num_i[BIT]};
    diff    = trial - {1'b0, size_i};
    num_nxt = num_i;
    rem_nxt = trial;
    num_nxt[BIT] = 1'b0;
    if (trial >= {1'b0, size_i}) begin
      rem_nxt      = diff;
      num_nxt[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign num_o = num_r;
  assign rem_o = rem_r;
endmodule
`default_nettype wire

// File: design/gib_axis.sv
// Axis stage: chain of division cells producing quotient and coordinate.
`default_nettype none
module gib_axis #(
  parameter int QW = 30,
  parameter int SW = 11
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [QW-1:0] num_i,
  input  wire logic [SW-1:0] size_i,
  output logic      [QW-1:0] quot_o,
  output logic      [SW-1:0] rem_o
);
  logic [QW-1:0] num_c [QW+1];
  logic [SW:0]   rem_c [QW+1];

  assign num_c[0] = num_i;
  assign rem_c[0] = '0;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    gib_cell #(.QW(QW), .SW(SW), .BIT(QW-1-i)) u_cell (
      .clk(clk), .en(en), .num_i(num_c[i]), .rem_i(rem_c[i]), .size_i(size_i),
      .num_o(num_c[i+1]), .rem_o(rem_c[i+1])
    );
  end

  assign quot_o = num_c[QW];
  assign rem_o  = rem_c[QW][SW-1:0];
endmodule
`default_nettype wire

// File: design/grid_index_boundary_bits.sv
// Top level: linear grid index to x/y/z coordinates with boundary bits.
// Throughput: one word per cycle unless the result register is held; each quotient bit is one cell of a chain.
// The whole pipe stalls together while the result register is held.
// Reset: synchronous active-low; clears valid bits, axis sizes return to 1.
`default_nettype none
module grid_index_boundary_bits #(
  parameter int AXIS_MAX   = gib_pkg::AXIS_MAX_DEF,
  parameter int INDEX_BITS = gib_pkg::INDEX_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [gib_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gib_pkg::CFG_DATA_W-1:0] cfg_data,
  gib_in_if.sink                              in_ch,
  gib_out_if.source                           out_ch
);
  import gib_pkg::*;

  localparam int SW    = $clog2(AXIS_MAX + 1);
  localparam int DEPTH = 3 * INDEX_BITS;
  localparam int CW    = COORD_W;

  logic [SW-1:0] size_r [NUM_AXES];
  logic [SW-1:0] wsize;
  logic [CFG_DATA_W-1:0] cfg_sat;

  always_comb begin
    cfg_sat = cfg_data;
    if (cfg_data == '0) cfg_sat = CFG_DATA_W'(1);
    else if (32'(cfg_data) > AXIS_MAX) cfg_sat = CFG_DATA_W'(AXIS_MAX);
    wsize = SW'(cfg_sat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NUM_AXES; a++) size_r[a] <= SW'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_AXIS_X: size_r[0] <= wsize;
        REG_AXIS_Y: size_r[1] <= wsize;
        REG_AXIS_Z: size_r[2] <= wsize;
        default: ;
      endcase
    end
  end

  // pipeline control: valid and opcode per stage, global enable
  logic             en;
  logic [DEPTH:0]   vld_r;
  logic [DEPTH:0]   op_r;
  logic             res_vld_r;

  assign en          = !res_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      res_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[DEPTH-1:0], in_ch.valid};
      res_vld_r <= vld_r[DEPTH];
    end
  end

  always_ff @(posedge clk) begin
    if (en) op_r <= {op_r[DEPTH-1:0], in_ch.opcode};
  end

  logic [INDEX_BITS-1:0] idx_r;
  always_ff @(posedge clk) begin
    if (en) idx_r <= in_ch.grid_index;
  end

  logic [INDEX_BITS-1:0] q0, q1, q2;
  logic [SW-1:0]         r0, r1, r2;
  logic [SW-1:0]         r0_d [2*INDEX_BITS];
  logic [SW-1:0]         r1_d [INDEX_BITS];

  gib_axis #(.QW(INDEX_BITS), .SW(SW)) u_ax_x (
    .clk(clk), .en(en), .num_i(idx_r), .size_i(size_r[0]), .quot_o(q0), .rem_o(r0));
  gib_axis #(.QW(INDEX_BITS), .SW(SW)) u_ax_y (
    .clk(clk), .en(en), .num_i(q0), .size_i(size_r[1]), .quot_o(q1), .rem_o(r1));
  gib_axis #(.QW(INDEX_BITS), .SW(SW)) u_ax_z (
    .clk(clk), .en(en), .num_i(q1), .size_i(size_r[2]), .quot_o(q2), .rem_o(r2));

  // align earlier coordinates with the z result
  always_ff @(posedge clk) begin
    if (en) begin
      r0_d[0] <= r0;
      for (int i = 1; i < 2*INDEX_BITS; i++) r0_d[i] <= r0_d[i-1];
      r1_d[0] <= r1;
      for (int i = 1; i < INDEX_BITS; i++) r1_d[i] <= r1_d[i-1];
    end
  end

  logic [SW-1:0] cx, cy, cz;
  logic [SW+1:0] reach;
  logic [2:0]    lo_nxt, up_nxt;
  logic [CW-1:0] cx_r, cy_r, cz_r;
  logic [2:0]    lo_r, up_r;
  logic          unused_q;

  assign unused_q = ^q2;

  always_comb begin
    cx = r0_d[2*INDEX_BITS-1];
    cy = r1_d[INDEX_BITS-1];
    cz = r2;
    reach = (op_t'(op_r[DEPTH]) == OP_CUBE) ? (SW+2)'(2) : (SW+2)'(1);
    lo_nxt = {cz == '0, cy == '0, cx == '0};
    up_nxt[0] = ((SW+2)'(cx) + reach) >= (SW+2)'(size_r[0]);
    up_nxt[1] = ((SW+2)'(cy) + reach) >= (SW+2)'(size_r[1]);
    up_nxt[2] = ((SW+2)'(cz) + reach) >= (SW+2)'(size_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r <= CW'(cx);
      cy_r <= CW'(cy);
      cz_r <= CW'(cz);
      lo_r <= lo_nxt;
      up_r <= up_nxt;
    end
  end

  assign out_ch.valid        = res_vld_r;
  assign out_ch.coord_x      = cx_r;
  assign out_ch.coord_y      = cy_r;
  assign out_ch.coord_z      = cz_r;
  assign out_ch.lower_bounds = lo_r;
  assign out_ch.upper_bounds = up_r ^ {2'b0, unused_q & 1'b0};
endmodule
`default_nettype wire

// File: design/gib_checker.sv
// Checker: port-level properties of the boundary bits block, bound to the top.
`default_nettype none
module gib_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       in_ready,
  input wire logic [9:0] coord_x,
  input wire logic [9:0] coord_y,
  input wire logic [2:0] lower_bounds
);
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("input stalled with empty output");
  a_lo_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (lower_bounds[0] == (coord_x == 10'd0))) else $error("x lower bit");
  a_lo_y: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (lower_bounds[1] == (coord_y == 10'd0))) else $error("y lower bit");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result word dropped");
endmodule

bind grid_index_boundary_bits gib_checker u_gib_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .in_ready(in_ch.ready), .coord_x(out_ch.coord_x), .coord_y(out_ch.coord_y),
  .lower_bounds(out_ch.lower_bounds)
);
`default_nettype wire

// File: tb/tb_top.sv
// Testbench for grid_index_boundary_bits: directed table plus random words, checked by a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import gib_pkg::*;

  localparam int LAT = 3 * INDEX_BITS_DEF + 2;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [2:0]         lo;
    logic [2:0]         up;
  } coord_word_t;

  typedef struct {
    op_t                       op;
    logic [INDEX_BITS_DEF-1:0] idx;
    bit                        typed;
    coord_word_t               res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gib_in_if #(.INDEX_BITS(INDEX_BITS_DEF)) in_ch ();
  gib_out_if #(.COORD_W(COORD_W)) out_ch ();

  grid_index_boundary_bits dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  int unsigned axis_len [NUM_AXES];
  coord_word_t coords_due [$];
  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  bit calm = 1'b0;
  bit rx_idle_on = 1'b1;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic coord_word_t decompose(op_t op, logic [INDEX_BITS_DEF-1:0] idx);
    coord_word_t r;
    longint unsigned k;
    longint unsigned c;
    longint unsigned s;
    logic [COORD_W-1:0] cc [NUM_AXES];
    k = idx;
    r.lo = '0;
    r.up = '0;
    for (int d = 0; d < NUM_AXES; d++) begin
      s = axis_len[d];
      c = k % s;
      k = k / s;
      cc[d] = c[COORD_W-1:0];
      if (c == 0) r.lo[d] = 1'b1;
      if (c + ((op == OP_CUBE) ? 2 : 1) >= s) r.up[d] = 1'b1;
    end
    r.x = cc[0];
    r.y = cc[1];
    r.z = cc[2];
    return r;
  endfunction

  task automatic write_axis(logic [CFG_IDX_W-1:0] i, logic [CFG_DATA_W-1:0] v);
    int unsigned s;
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= i;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    s = (v == 0) ? 1 : ((v > AXIS_MAX_DEF) ? AXIS_MAX_DEF : v);
    if (i < NUM_AXES) axis_len[i] = s;
  endtask

  // hold until every result is back, then let the pipe drain
  task automatic drain();
    while (coords_due.size() != 0) @(negedge clk);
    repeat (LAT + 4) @(negedge clk);
  endtask

  task automatic send_word(op_t op, logic [INDEX_BITS_DEF-1:0] idx);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.grid_index <= idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    coords_due.push_back(decompose(op, idx));
    words_in++;
    @(negedge clk);
  endtask

  task automatic send_random(int n);
    op_t op;
    logic [INDEX_BITS_DEF-1:0] idx;
    int unsigned cells;
    for (int i = 0; i < n; i++) begin
      op = op_t'($urandom_range(0, 1));
      cells = axis_len[0] * axis_len[1] * axis_len[2];
      case ($urandom_range(0, 3))
        0: idx = INDEX_BITS_DEF'($urandom());
        1: idx = (cells > 1) ? INDEX_BITS_DEF'($urandom_range(0, cells - 1)) : '0;
        default: idx = INDEX_BITS_DEF'($urandom_range(0, 2 * cells));
      endcase
      send_word(op, idx);
    end
    in_ch.valid <= 1'b0;
  endtask

  // result side: random back-pressure, check against oldest expectation
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    coord_word_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      words_out++;
      if (coords_due.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = coords_due.pop_front();
        if (out_ch.coord_x !== e.x) begin
          $error("coord_x expected %0d actual %0d", e.x, out_ch.coord_x); errors++;
        end
        if (out_ch.coord_y !== e.y) begin
          $error("coord_y expected %0d actual %0d", e.y, out_ch.coord_y); errors++;
        end
        if (out_ch.coord_z !== e.z) begin
          $error("coord_z expected %0d actual %0d", e.z, out_ch.coord_z); errors++;
        end
        if (out_ch.lower_bounds !== e.lo) begin
          $error("lower_bounds expected %b actual %b", e.lo, out_ch.lower_bounds); errors++;
        end
        if (out_ch.upper_bounds !== e.up) begin
          $error("upper_bounds expected %b actual %b", e.up, out_ch.upper_bounds); errors++;
        end
      end
    end
  end

  initial begin
    dir_row_t rows [$];
    dir_row_t r;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_VERTEX;
    in_ch.grid_index = '0;
    for (int d = 0; d < NUM_AXES; d++) axis_len[d] = 1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // after reset every axis is size 1: coords 0, all bounds set
    rows.push_back('{OP_VERTEX, 30'd0, 1'b1, '{0, 0, 0, 3'b111, 3'b111}});
    rows.push_back('{OP_CUBE, 30'h3FFFFFFF, 1'b1, '{0, 0, 0, 3'b111, 3'b111}});
    rows.push_back('{OP_VERTEX, 30'h2AAAAAAA, 1'b1, '{0, 0, 0, 3'b111, 3'b111}});
    rows.push_back('{OP_CUBE, 30'h15555555, 1'b1, '{0, 0, 0, 3'b111, 3'b111}});
    foreach (rows[i]) begin
      r = rows[i];
      if (r.typed && decompose(r.op, r.idx) != r.res) begin
        $error("table row %0d disagrees with predictor", i); errors++;
      end
      send_word(r.op, r.idx);
    end
    in_ch.valid <= 1'b0;
    drain();

    // largest sizes, oversize saturates, zero acts as one
    write_axis(REG_AXIS_X, 11'd1024);
    write_axis(REG_AXIS_Y, 11'd2047);
    write_axis(REG_AXIS_Z, 11'd0);
    write_axis(2'd3, 11'd5);
    foreach (rows[i]) send_word(rows[i].op, rows[i].idx);
    send_word(OP_VERTEX, 30'd1023);
    send_word(OP_CUBE, 30'd1022);
    send_word(OP_CUBE, 30'd1021);
    send_word(OP_VERTEX, 30'd1024);
    send_word(OP_VERTEX, 30'hFFFFF);
    send_word(OP_CUBE, 30'h100000);
    in_ch.valid <= 1'b0;
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      for (int d = 0; d < NUM_AXES; d++) begin
        case ($urandom_range(0, 4))
          0: write_axis(cfg_reg_t'(d), CFG_DATA_W'($urandom()));
          1: write_axis(cfg_reg_t'(d), CFG_DATA_W'($urandom_range(0, 2)));
          default: write_axis(cfg_reg_t'(d), CFG_DATA_W'($urandom_range(1, 40)));
        endcase
      end
      if (ph == 9) calm = 1'b1;
      send_random(74);
      drain();
    end

    $display("Covered %0d index words over ten axis settings, sizes from zero to past max.",
             words_in);
    $display("Checked %0d result words, with random stalls on both channels.", words_out);
    if (errors == 0 && coords_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
